### rtl/gs2d_pkg.sv
`default_nettype none
package gs2d_pkg;

    // default build constants
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 5;
    localparam int MAX_HEIGHT     = 4096;

    // fixed field widths
    localparam int HW      = 13;   // row counters and frame height
    localparam int PIX_W   = 16;
    localparam int VAL_W   = 32;
    localparam int TAP_W   = 16;
    localparam int NUM_TAP = 6;
    localparam int ACC_W   = 58;
    localparam int CFG_IW  = 3;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TAP_CENTER   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_TAP_FIVE     = 3'd7;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1024;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;   // input beat taken
        logic start;    // begin a window sum
        logic step;     // issue one window position
        logic latch;    // register the rounded result
        logic take;     // output beat taken
    } t_cmd;

    typedef struct packed {
        logic out_ready;
        logic scan_last;
        logic pipe_empty;
    } t_status;

endpackage
`default_nettype wire

### rtl/gs2d_ctrl.sv
`default_nettype none
module gs2d_ctrl
    import gs2d_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CHECK;
            S_CHECK: n_state = i_status.out_ready ? S_MAC : S_IDLE;
            S_MAC:   if (i_status.scan_last) n_state = S_DRAIN;
            S_DRAIN: if (i_status.pipe_empty) n_state = S_OUT;
            S_OUT:   if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_out_valid  = (r_state == S_OUT);
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.start  = (r_state == S_CHECK) && i_status.out_ready;
        o_cmd.step   = (r_state == S_MAC);
        o_cmd.latch  = (r_state == S_DRAIN) && i_status.pipe_empty;
        o_cmd.take   = (r_state == S_OUT) && i_out_ready;
    end

endmodule
`default_nettype wire

### rtl/gs2d_datapath.sv
`default_nettype none
module gs2d_datapath
    import gs2d_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  wire                     i_cfg_valid,
    input  wire  [CFG_IW-1:0]       i_cfg_index,
    input  wire  [TAP_W-1:0]        i_cfg_data,
    input  wire  [PIX_W-1:0]        i_pixel,
    input  wire                     i_flush,
    output logic [VAL_W-1:0]        o_value,
    output logic                    o_last
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = CW + 1;
    localparam int RING = 2 * MAX_RADIUS + 2;
    localparam int SW   = $clog2(RING);
    localparam int AW   = $clog2(RING * MAX_WIDTH);
    localparam int DW   = $clog2(MAX_RADIUS + 1) + 1;
    localparam int XW   = CW + 2;
    localparam int YW   = HW + 2;
    localparam int ZW   = SW + 2;
    localparam int PW   = PIX_W + 2 * TAP_W + 1;

    // configuration registers
    logic [10:0]      r_frame_width;
    logic [12:0]      r_frame_height;
    logic [TAP_W-1:0] r_tap [NUM_TAP];

    // frame position state
    logic [WW-1:0] r_act_w, w_eff;
    logic [HW-1:0] r_act_h, h_eff;
    logic [CW-1:0] r_in_col, r_out_col;
    logic [HW-1:0] r_in_row, r_out_row;
    logic [SW-1:0] r_in_slot, r_out_slot;

    logic [PIX_W-1:0] r_mem [RING * MAX_WIDTH];

    // window scan and multiply pipeline
    logic signed [DW-1:0]    r_dy, r_dx;
    logic [PIX_W-1:0]        r_rd, r_pix2;
    logic [TAP_W-1:0]        r_ta, r_tb;
    logic [2*TAP_W-1:0]      r_w;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic r_v1, r_v2, r_v3, r_b1, r_b2, r_b3;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_tap[0] <= 16'd26155;
            r_tap[1] <= 16'd15862;
            r_tap[2] <= 16'd3539;
            r_tap[3] <= 16'd290;
            r_tap[4] <= 16'd0;
            r_tap[5] <= 16'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[12:0];
                default:          r_tap[3'(i_cfg_index - REG_TAP_CENTER)] <= i_cfg_data;
            endcase
        end
    end

    // frame size seen by this beat, latched at the frame start
    logic frame_start;
    assign frame_start = (r_in_row == '0) && (r_in_col == '0) &&
                         (r_out_row == '0) && (r_out_col == '0);

    always_comb begin
        w_eff = r_act_w;
        h_eff = r_act_h;
        if (frame_start) begin
            if (r_frame_width == '0)
                w_eff = WW'(1);
            else if (32'(r_frame_width) > 32'(MAX_WIDTH))
                w_eff = WW'(MAX_WIDTH);
            else
                w_eff = WW'(r_frame_width);
            if (r_frame_height == '0)
                h_eff = HW'(1);
            else if (32'(r_frame_height) > 32'(MAX_HEIGHT))
                h_eff = HW'(MAX_HEIGHT);
            else
                h_eff = r_frame_height;
        end
    end

    logic pix_write;
    assign pix_write = i_cmd.accept && !i_flush && (r_in_row < h_eff);

    // last output of the frame
    logic out_is_last;
    assign out_is_last = (r_out_row == r_act_h - HW'(1)) &&
                         (WW'(r_out_col) == r_act_w - WW'(1));

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_w    <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
            r_act_h    <= HW'(1024);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
        end else begin
            if (i_cmd.accept && !i_flush) begin
                r_act_w <= w_eff;
                r_act_h <= h_eff;
            end
            if (pix_write) begin
                if (WW'(r_in_col) + WW'(1) >= w_eff) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + HW'(1);
                    r_in_slot <= (r_in_slot == SW'(RING - 1)) ? '0 : r_in_slot + SW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
            if (i_cmd.take) begin
                if (out_is_last) begin
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_slot  <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_slot <= '0;
                end else if (WW'(r_out_col) + WW'(1) >= r_act_w) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + HW'(1);
                    r_out_slot <= (r_out_slot == SW'(RING - 1)) ? '0 : r_out_slot + SW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // output ready: input has passed the lower right corner of the window
    logic [HW:0]   rr;
    logic [WW-1:0] cc;
    always_comb begin
        rr = {1'b0, r_out_row} + (HW+1)'(MAX_RADIUS);
        if (rr > {1'b0, r_act_h - HW'(1)}) rr = {1'b0, r_act_h - HW'(1)};
        cc = WW'(r_out_col) + WW'(MAX_RADIUS);
        if (cc > r_act_w - WW'(1)) cc = r_act_w - WW'(1);
        o_status.out_ready = (r_out_row < r_act_h) &&
            (({1'b0, r_in_row} > rr) || (({1'b0, r_in_row} == rr) && (WW'(r_in_col) > cc)));
    end

    // window position under scan
    logic signed [XW-1:0] x_s;
    logic signed [YW-1:0] y_s;
    logic signed [ZW-1:0] z_s;
    logic                 in_frame;
    logic [SW-1:0]        y_slot;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [DW-1:0]        adx, ady;

    always_comb begin
        x_s = $signed({2'b00, r_out_col}) + XW'(r_dx);
        y_s = $signed({2'b00, r_out_row}) + YW'(r_dy);
        z_s = $signed({2'b00, r_out_slot}) + ZW'(r_dy);
        if (z_s < 0)
            z_s = z_s + $signed(ZW'(RING));
        else if (z_s >= $signed(ZW'(RING)))
            z_s = z_s - $signed(ZW'(RING));
        y_slot   = z_s[SW-1:0];
        in_frame = (x_s >= 0) && (x_s < $signed({1'b0, r_act_w})) &&
                   (y_s >= 0) && (y_s < $signed({2'b00, r_act_h}));
        rd_addr  = in_frame ? AW'(y_slot) * AW'(MAX_WIDTH) + AW'(x_s[CW-1:0]) : '0;
        wr_addr  = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
        adx      = (r_dx < 0) ? DW'(-r_dx) : DW'(r_dx);
        ady      = (r_dy < 0) ? DW'(-r_dy) : DW'(r_dy);
    end

    assign o_status.scan_last = (r_dy == DW'(MAX_RADIUS)) && (r_dx == DW'(MAX_RADIUS));
    assign o_status.pipe_empty = !(r_b1 || r_b2 || r_b3);

    // line store
    always_ff @(posedge i_clk) begin
        if (pix_write) r_mem[wr_addr] <= i_pixel;
        if (i_cmd.step) r_rd <= r_mem[rd_addr];
    end

    // scan counters and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dy <= '0;
            r_dx <= '0;
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_b1 <= 1'b0; r_b2 <= 1'b0; r_b3 <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_dy <= -DW'(MAX_RADIUS);
                r_dx <= -DW'(MAX_RADIUS);
            end else if (i_cmd.step) begin
                if (r_dx == DW'(MAX_RADIUS)) begin
                    r_dx <= -DW'(MAX_RADIUS);
                    r_dy <= r_dy + DW'(1);
                end else begin
                    r_dx <= r_dx + DW'(1);
                end
            end
            r_b1 <= i_cmd.step;
            r_v1 <= i_cmd.step && in_frame;
            r_b2 <= r_b1; r_v2 <= r_v1;
            r_b3 <= r_b2; r_v3 <= r_v2;
        end
    end

    // tap product, pixel product and accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_ta <= r_tap[3'(adx)];
            r_tb <= r_tap[3'(ady)];
        end
        r_w    <= r_ta * r_tb;
        r_pix2 <= r_rd;
        r_prod <= PW'($signed(r_pix2) * $signed({1'b0, r_w}));
        if (i_cmd.start)
            r_acc <= '0;
        else if (r_v3)
            r_acc <= r_acc + ACC_W'(r_prod);
    end

    // round to nearest, ties up, and saturate
    logic signed [ACC_W-1:0]    rnd;
    logic signed [ACC_W-17:0]   q;
    always_comb begin
        rnd = r_acc + ACC_W'(32768);
        q   = rnd[ACC_W-1:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            if (q > $signed((ACC_W-16)'(32'h7FFF_FFFF)))
                o_value <= 32'h7FFF_FFFF;
            else if (q < -$signed((ACC_W-16)'(33'h0_8000_0000)))
                o_value <= 32'h8000_0000;
            else
                o_value <= q[VAL_W-1:0];
            o_last <= out_is_last;
        end
    end

endmodule
`default_nettype wire

### rtl/gaussian_smooth_2d_core.sv
// 2D Gaussian smoother for a raster stream of signed 16-bit pixels.
// Input stream: s_axis_tdata carries one pixel, s_axis_tuser set marks a
// flush beat that carries no pixel and only drains one pending output.
// Output stream: m_axis_tdata is the smoothed pixel in signed Q15.16,
// m_axis_tlast marks the last output of the frame.
// Config channel: index 0 width, 1 height, 2..7 taps for distance 0..5;
// the user must write it only while the block is idle (the block does
// not enforce it); size taken at the frame start. One beat at a time: a
// beat is taken in the idle state, a beat that yields no output frees
// the input after the check state; one that yields an output passes
// the check state, scans (2*MAX_RADIUS+1)^2 window positions in the
// single multiply-accumulate unit, one window position a cycle, drains
// the pipeline and offers the result. The input stays closed until
// that output is taken, so a stalled receiver holds the whole block.
// Reset returns counters to the start of a frame and the registers to
// their defaults; the line store needs no clearing.
`default_nettype none
module gaussian_smooth_2d_core
    import gs2d_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire  [PIX_W-1:0]   s_axis_tdata,   // [15:0] pixel
    input  wire                s_axis_tuser,   // [0] flush
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    output logic [VAL_W-1:0]   m_axis_tdata,   // [31:0] value
    output logic               m_axis_tlast,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [CFG_IW-1:0]  i_cfg_index,
    input  wire  [TAP_W-1:0]   i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    gs2d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // line store, counters and multiply-accumulate
    gs2d_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (s_axis_tdata),
        .i_flush     (s_axis_tuser),
        .o_value     (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule
`default_nettype wire
